@@ rtl/core/pqs_pkg.sv @@
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared widths, command codes and register indexes of the scan block.
// ----------------------------------------------------------------------------
package pqs_pkg;
    localparam int GROUP_COUNT_DEF = 16;
    localparam int CODE_BITS_DEF   = 8;
    localparam int K_MAX_DEF       = 16;
    localparam int ADDR_W          = 12;
    localparam int TABLE_DEPTH     = 4096;
    localparam int VAL_W           = 24;
    localparam int SCORE_W         = 32;
    localparam int ID_W            = 24;
    localparam int ACC_W           = 37;
    localparam int CFG_W           = 5;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SCORE = 2'd1;
    localparam logic [1:0] CMD_EMIT  = 2'd2;

    localparam logic [0:0] REG_TOP_K  = 1'b0;
    localparam logic [0:0] REG_GROUPS = 1'b1;

    // Word handed from one store cell to the next.
    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
    } pqs_entry_t;

    // Command broadcast to every cell of the store.
    typedef struct packed {
        logic               offer;
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
        logic               shift;
        logic               clear;
    } pqs_ctrl_t;
endpackage

@@ rtl/core/pqs_ram.sv @@
// ----------------------------------------------------------------------------
// pqs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pqs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/core/pqs_cell.sv @@
// ----------------------------------------------------------------------------
// pqs_cell
// One slot of the sorted store; inserts, shifts on emit, or clears.
// ----------------------------------------------------------------------------
module pqs_cell
    import pqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       enable,
    input  pqs_ctrl_t  ctrl,
    input  pqs_entry_t prev,
    input  logic       prev_ge,
    output pqs_entry_t cur,
    output logic       cur_ge
);
    pqs_entry_t e_reg, e_next;
    pqs_entry_t newe;

    // This held entry stays ahead of the new one when it scores equal or better.
    assign cur_ge = e_reg.valid &&
                    ($signed(e_reg.score) >= $signed(ctrl.score));
    assign cur    = e_reg;

    always_comb
    begin
        newe.valid = 1'b1;
        newe.score = ctrl.score;
        newe.id    = ctrl.id;
        e_next = e_reg;
        if (ctrl.clear || !enable)
        begin
            e_next.valid = 1'b0;
        end
        else if (ctrl.shift)
        begin
            e_next = prev;
        end
        else if (ctrl.offer && !cur_ge)
        begin
            e_next = prev_ge ? newe : prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg <= '0;
        end
        else
        begin
            e_reg <= e_next;
        end
    end
endmodule

@@ rtl/core/pqs_chain.sv @@
// ----------------------------------------------------------------------------
// pqs_chain
// Row of store cells; cell 0 holds the best entry.
// ----------------------------------------------------------------------------
module pqs_chain
    import pqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pqs_ctrl_t                  ctrl,
    input  logic [$clog2(DEPTH+1)-1:0] keep,
    output pqs_entry_t                 head
);
    pqs_entry_t ent [DEPTH+1];
    logic       ge  [DEPTH];

    assign ent[DEPTH] = '0;
    assign head       = ent[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        pqs_entry_t pv;
        logic       pg;
        localparam logic [$clog2(DEPTH+1)-1:0] IDX = ($clog2(DEPTH+1))'(i);
        // Offers move entries toward the tail; emit shifts toward the head.
        assign pv = ctrl.shift ? ent[i+1] : ((i == 0) ? '0 : ent[(i == 0) ? 0 : i-1]);
        assign pg = (i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i-1];
        pqs_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .enable (IDX < keep),
            .ctrl   (ctrl),
            .prev   (pv),
            .prev_ge(pg),
            .cur    (ent[i]),
            .cur_ge (ge[i])
        );
    end
endmodule

@@ rtl/core/pq_scan_top_k.sv @@
// ----------------------------------------------------------------------------
// pq_scan_top_k
// Product-quantization table scan feeding a sorted top-k store.
// ----------------------------------------------------------------------------
// Usage: the s_axis channel takes command words. A load word writes one
// table entry, a score word sums the cluster score and one table entry per
// active group and offers the saturated total to the store, and an emit word
// sends the held entries best first on m_axis, tlast on the final one, then
// clears the store. An empty store emits one word with valid_res low.
// A score word keeps the input busy until its total is offered (values of
// active_groups above GROUP_COUNT count as GROUP_COUNT): the single table
// RAM port is read once per group, one group per cycle, and the sum is
// saturated and offered in the last step. A load word is written as it is
// accepted and leaves the input ready. An emit sends one word per held entry,
// each entry shifted out of the cell row as its word is taken. The config
// channel writes top_k (index 0) and active_groups (index 1).
// After reset the store is empty, top_k is 1 and active_groups is 16; the
// table is undefined until loaded. When m_axis stalls, the current result
// word holds and no new command is accepted until the emit finishes.
// ----------------------------------------------------------------------------
module pq_scan_top_k
    import pqs_pkg::*;
#(
    parameter int GROUP_COUNT = GROUP_COUNT_DEF,
    parameter int CODE_BITS   = CODE_BITS_DEF,
    parameter int K_MAX       = K_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: table_addr[11:0], table_value[35:12],
    // codes_low[99:36], codes_high[163:100], vector_id[187:164],
    // cluster_score[219:188], zero fill to 224.
    input  logic [223:0] s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: result_id[23:0], result_score[55:24], rank[59:56].
    output logic [63:0]  m_axis_tdata,
    // tuser: valid_res.
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [4:0]   cfg_data
);
    localparam int DEPTH = (K_MAX < 16) ? K_MAX : 16;
    localparam int KW    = $clog2(DEPTH+1);
    localparam int GW    = $clog2(GROUP_COUNT+1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_OFF  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CFG_W-1:0]     topk_reg, groups_reg;
    logic [KW-1:0]        keep;
    logic [GW-1:0]        ngrp;
    logic [GW-1:0]        g_reg;
    logic                 rv_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [127:0]         codes_reg;
    logic [ID_W-1:0]      id_reg;
    logic [KW-1:0]        held_reg;
    logic [3:0]           rank_reg;
    logic                 empty_reg;
    logic                 accept;
    logic [1:0]           cmd;
    logic [ADDR_W-1:0]    raddr;
    logic [VAL_W-1:0]     rdata;
    logic                 we;
    logic [7:0]           code_b;
    pqs_ctrl_t            ctrl;
    pqs_entry_t           head;
    logic [SCORE_W-1:0]   sat;
    logic                 out_take;

    assign cmd    = s_axis_tuser;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);

    always_comb
    begin
        keep = (topk_reg == '0) ? KW'(1) :
               ((topk_reg > CFG_W'(DEPTH)) ? KW'(DEPTH) : KW'(topk_reg));
        ngrp = (groups_reg > CFG_W'(GROUP_COUNT)) ? GW'(GROUP_COUNT) : GW'(groups_reg);
    end

    // Table read: group g_reg, its code byte masked to CODE_BITS.
    assign code_b = codes_reg[8*(4'(g_reg)) +: 8] & 8'((1 << CODE_BITS) - 1);
    assign we     = accept && (cmd == CMD_LOAD);
    assign raddr  = we ? s_axis_tdata[11:0]
                       : ADDR_W'((32'(g_reg) << CODE_BITS) + 32'(code_b));

    pqs_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_table (
        .clk  (clk),
        .we   (we),
        .addr (raddr),
        .wdata(s_axis_tdata[35:12]),
        .rdata(rdata)
    );

    always_comb
    begin
        if ($signed(acc_reg) > $signed(ACC_W'(32'sh7fffffff)))
            sat = 32'h7fffffff;
        else if ($signed(acc_reg) < -$signed({{(ACC_W-SCORE_W){1'b0}}, 32'h80000000}))
            sat = 32'h80000000;
        else
            sat = acc_reg[SCORE_W-1:0];
    end

    assign out_take = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        ctrl.offer = (state_reg == ST_OFF);
        ctrl.score = sat;
        ctrl.id    = id_reg;
        ctrl.shift = (state_reg == ST_EMIT) && out_take;
        ctrl.clear = 1'b0;
    end

    pqs_chain #(.DEPTH(DEPTH)) u_chain (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (ctrl),
        .keep (keep),
        .head (head)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd == CMD_SCORE)
                    state_next = ST_SUM;
                else if (accept && cmd == CMD_EMIT)
                    state_next = ST_EMIT;
            end
            ST_SUM:
            begin
                if (!rv_reg && g_reg >= ngrp)
                    state_next = ST_OFF;
            end
            ST_OFF:
                state_next = ST_IDLE;
            ST_EMIT:
            begin
                if (out_take && m_axis_tlast)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            topk_reg   <= CFG_W'(1);
            groups_reg <= CFG_W'(16);
            held_reg   <= '0;
            g_reg      <= '0;
            rv_reg     <= 1'b0;
            rank_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TOP_K)
                    topk_reg <= cfg_data;
                else
                    groups_reg <= cfg_data;
            end
            // A smaller top_k drops the worst entries on the following edge.
            if (held_reg > keep)
                held_reg <= keep;
            // rv_reg marks that rdata holds the entry of group g_reg - 1.
            rv_reg <= (state_reg == ST_SUM) && (g_reg < ngrp);
            if (accept)
                g_reg <= '0;
            else if (state_reg == ST_SUM && g_reg < ngrp)
                g_reg <= g_reg + GW'(1);
            if (state_reg == ST_OFF && held_reg < keep)
            begin
                held_reg <= held_reg + KW'(1);
            end
            if (accept && cmd == CMD_EMIT)
                rank_reg <= '0;
            else if (ctrl.shift)
            begin
                rank_reg <= rank_reg + 4'd1;
                if (m_axis_tlast)
                    held_reg <= '0;
            end
        end
    end

    // held count grows with each offer while the store holds fewer than keep
    // entries; a drop happens only when the store is full.

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            codes_reg <= s_axis_tdata[163:36];
            id_reg    <= s_axis_tdata[187:164];
            acc_reg   <= ACC_W'($signed(s_axis_tdata[219:188]));
            empty_reg <= (held_reg == '0);
        end
        else if (rv_reg)
        begin
            acc_reg <= acc_reg + ACC_W'($signed(rdata));
        end
    end

    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tuser  = !empty_reg;
    assign m_axis_tlast  = empty_reg || (KW'(rank_reg) + KW'(1) >= held_reg);
    assign m_axis_tdata  = empty_reg ? 64'd0 :
                           {4'd0, rank_reg, head.score, head.id};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while emitting");
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (held_reg <= KW'(DEPTH)))
        else $error("held count beyond store depth");
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && m_axis_tlast) |=> (held_reg == '0))
        else $error("store not cleared after emit");
endmodule
